@@ hdl/bmc_pkg.sv @@
// shared types, register codes, shift/sign-extend helpers for the compensation unit
// no dependencies

package bmc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int QDepth   = 2;

  // configuration register codes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_CAL    = 3'd0,
    REG_PRESS_CAL_A = 3'd1,
    REG_PRESS_CAL_B = 3'd2,
    REG_PRESS_CAL_C = 3'd3,
    REG_HUM_CAL     = 3'd4
  } reg_idx_t;

  // unpacked raw burst
  typedef struct packed {
    logic [19:0] adc_p;
    logic [19:0] adc_t;
    logic [15:0] adc_h;
  } raw_t;

  // calibration words
  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [15:0] pc;
    logic [63:0] hum;
  } cal_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
    return 64'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

@@ hdl/bme280_measurement_compensation_unit.sv @@
// top level of the measurement compensation unit: configuration registers,
// front end, burst queue and compensation sequencer
// depends on bmc_pkg, bmc_front, bmc_queue, bmc_back
//
//  channel   | handshake           | beat
//  ----------+---------------------+-------------------------------------------
//  burst in  | start / busy        | eight raw bytes, taken when start && !busy
//  result    | done (one cycle)    | temperature, pressure, pressure_valid,
//            |                     | humidity
//  config    | cfg_we              | cfg_index selects register, cfg_data value
//
// each burst is taken from the queue, then runs 21 multiplies on the shared
// 32x32 multiplier and one radix-2 divide (the divide and four multiplies are
// skipped when the pressure divisor is zero)
// the front end keeps taking bursts into a two-entry queue while the sequencer
// works; busy rises only when the queue is full
// rst is synchronous and clears queue, sequencer state and calibration words
// results cannot be held off: each is valid in the cycle done is high and holds only until the next burst overwrites it

module bme280_measurement_compensation_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        press_msb,
  input  logic [7:0]                        press_lsb,
  input  logic [7:0]                        press_xlsb,
  input  logic [7:0]                        temp_msb,
  input  logic [7:0]                        temp_lsb,
  input  logic [7:0]                        temp_xlsb,
  input  logic [7:0]                        hum_msb,
  input  logic [7:0]                        hum_lsb,
  input  logic                              cfg_we,
  input  logic [bmc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [bmc_pkg::CfgDataW-1:0]      cfg_data,
  output logic                              done,
  output logic signed [31:0]                temperature,
  output logic [31:0]                       pressure,
  output logic                              pressure_valid,
  output logic [16:0]                       humidity
);

  bmc_pkg::cal_t cal;
  bmc_pkg::raw_t entry;
  bmc_pkg::raw_t head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  // calibration words, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmc_pkg::REG_TEMP_CAL:    cal.temp <= cfg_data[47:0];
        bmc_pkg::REG_PRESS_CAL_A: cal.pa   <= cfg_data;
        bmc_pkg::REG_PRESS_CAL_B: cal.pb   <= cfg_data;
        bmc_pkg::REG_PRESS_CAL_C: cal.pc   <= cfg_data[15:0];
        bmc_pkg::REG_HUM_CAL:     cal.hum  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bmc_front u_front (
    .start      (start),
    .press_msb  (press_msb),
    .press_lsb  (press_lsb),
    .press_xlsb (press_xlsb),
    .temp_msb   (temp_msb),
    .temp_lsb   (temp_lsb),
    .temp_xlsb  (temp_xlsb),
    .hum_msb    (hum_msb),
    .hum_lsb    (hum_lsb),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .entry      (entry)
  );

  bmc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  bmc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cal            (cal),
    .q_empty        (q_empty),
    .q_head         (head),
    .q_pop          (pop),
    .done           (done),
    .temperature    (temperature),
    .pressure       (pressure),
    .pressure_valid (pressure_valid),
    .humidity       (humidity)
  );

endmodule

@@ hdl/bmc_front.sv @@
// front end: takes a raw burst and unpacks the three adc values
// depends on bmc_pkg

module bmc_front (
  input  logic            start,
  input  logic [7:0]      press_msb,
  input  logic [7:0]      press_lsb,
  input  logic [7:0]      press_xlsb,
  input  logic [7:0]      temp_msb,
  input  logic [7:0]      temp_lsb,
  input  logic [7:0]      temp_xlsb,
  input  logic [7:0]      hum_msb,
  input  logic [7:0]      hum_lsb,
  input  logic            q_full,
  output logic            busy,
  output logic            push,
  output bmc_pkg::raw_t   entry
);

  assign busy = q_full;
  assign push = start && !q_full;

  // lower xlsb nibbles carry nothing
  always_comb begin
    entry.adc_p = {press_msb, press_lsb, press_xlsb[7:4]};
    entry.adc_t = {temp_msb, temp_lsb, temp_xlsb[7:4]};
    entry.adc_h = {hum_msb, hum_lsb};
  end

endmodule

@@ hdl/bmc_queue.sv @@
// two-entry queue between front end and compensation sequencer
// depends on bmc_pkg

module bmc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bmc_pkg::raw_t   wdata,
  input  logic            pop,
  output bmc_pkg::raw_t   head,
  output logic            full,
  output logic            empty
);

  bmc_pkg::raw_t mem [bmc_pkg::QDepth];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'(bmc_pkg::QDepth));
  assign empty = (cnt == 2'd0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        mem[wp] <= wdata;
        wp      <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

@@ hdl/bmc_mul.sv @@
// 64-bit wrapping multiplier from one 32x32 multiplier, three partial products
// no package dependencies

module bmc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] acc;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] opx;
  logic [31:0] opy;
  logic [63:0] prod;

  assign p = acc;

  // low x low, then the two cross terms (only their low halves survive)
  always_comb begin
    case (cnt)
      2'd0: begin
        opx = ra[31:0];
        opy = rb[31:0];
      end
      2'd1: begin
        opx = ra[31:0];
        opy = rb[63:32];
      end
      default: begin
        opx = ra[63:32];
        opy = rb[31:0];
      end
    endcase
    prod = 64'(opx) * 64'(opy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        ra   <= a;
        rb   <= b;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        case (cnt)
          2'd0: begin
            acc <= prod;
            cnt <= 2'd1;
          end
          2'd1: begin
            acc <= acc + {prod[31:0], 32'd0};
            cnt <= 2'd2;
          end
          default: begin
            acc  <= acc + {prod[31:0], 32'd0};
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

@@ hdl/bmc_div.sv @@
// signed 64-bit divider, truncating, one quotient bit per cycle
// no package dependencies

module bmc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] n,
  input  logic [63:0] d,
  output logic        done,
  output logic [63:0] q
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] ud;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] rsh;
  logic [64:0] diff;
  logic        ge;

  assign rsh  = {rem, quo[63]};
  assign diff = rsh - {1'b0, ud};
  assign ge   = !diff[64];
  // most negative over minus one wraps back to itself
  assign q    = neg ? (64'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (go) begin
        quo  <= n[63] ? (64'd0 - n) : n;
        ud   <= d[63] ? (64'd0 - d) : d;
        neg  <= n[63] ^ d[63];
        rem  <= 64'd0;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[63:0] : rsh[63:0];
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/bmc_back.sv @@
// compensation sequencer: temperature, pressure and humidity steps on shared units
// depends on bmc_pkg, bmc_mul, bmc_div

module bmc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bmc_pkg::cal_t        cal,
  input  logic                 q_empty,
  input  bmc_pkg::raw_t        q_head,
  output logic                 q_pop,
  output logic                 done,
  output logic signed [31:0]   temperature,
  output logic [31:0]          pressure,
  output logic                 pressure_valid,
  output logic [16:0]          humidity
);

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_T3,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_PDIV, S_P8, S_P9, S_P10,
    S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8
  } state_t;

  state_t        st;
  logic          pend;
  bmc_pkg::raw_t raw;

  logic [31:0] v1;
  logic [31:0] tf;
  logic [63:0] aa;
  logic [63:0] bb;
  logic [63:0] s;
  logic [63:0] pn;
  logic [63:0] c;
  logic [31:0] hx;
  logic [31:0] hy;
  logic [31:0] hy2;
  logic [31:0] hz;
  logic [31:0] hv;

  logic        mul_go;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mp;
  logic        div_go;
  logic        div_done;
  logic [63:0] dq;

  logic [31:0] t1;
  logic [31:0] xt;
  logic [31:0] dt;
  logic [63:0] pa_a;
  logic [63:0] pp;
  logic [63:0] q13;
  logic [31:0] hvv;
  logic [63:0] psum;
  logic [63:0] pfin;
  logic [31:0] hfin;
  logic [31:0] hclamp;

  always_comb begin
    t1     = {16'd0, cal.temp[15:0]};
    xt     = {15'd0, raw.adc_t[19:3]} - {15'd0, cal.temp[15:0], 1'b0};
    dt     = {16'd0, raw.adc_t[19:4]} - t1;
    pa_a   = bmc_pkg::sx32(tf) - 64'd128000;
    pp     = 64'd1048576 - {44'd0, raw.adc_p};
    q13    = bmc_pkg::asr64(pn, 13);
    hvv    = tf - 32'd76800;
    psum   = pn + c + bmc_pkg::asr64(mp, 19);
    pfin   = bmc_pkg::asr64(psum, 8) + (bmc_pkg::sx16(cal.pb[47:32]) << 4);
    hfin   = hv - bmc_pkg::asr32(bmc_pkg::asr32(mp[31:0], 4), 0);
    if (hfin[31]) begin
      hclamp = 32'd0;
    end else if (hfin > 32'd419430400) begin
      hclamp = 32'd419430400;
    end else begin
      hclamp = hfin;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = 64'd0;
    mul_b = 64'd0;
    case (st)
      S_T1: begin
        mul_a = bmc_pkg::sx32(xt);
        mul_b = bmc_pkg::sx16(cal.temp[31:16]);
      end
      S_T2: begin
        mul_a = bmc_pkg::sx32(dt);
        mul_b = bmc_pkg::sx32(dt);
      end
      S_T3: begin
        mul_a = bmc_pkg::sx32(v1);
        mul_b = bmc_pkg::sx16(cal.temp[47:32]);
      end
      S_P1: begin
        mul_a = pa_a;
        mul_b = pa_a;
      end
      S_P2: begin
        mul_a = aa;
        mul_b = bmc_pkg::sx16(cal.pb[31:16]);
      end
      S_P3: begin
        mul_a = pa_a;
        mul_b = bmc_pkg::sx16(cal.pb[15:0]);
      end
      S_P4: begin
        mul_a = aa;
        mul_b = bmc_pkg::sx16(cal.pa[47:32]);
      end
      S_P5: begin
        mul_a = pa_a;
        mul_b = bmc_pkg::sx16(cal.pa[31:16]);
      end
      S_P6: begin
        mul_a = (64'd1 << 47) + s;
        mul_b = {48'd0, cal.pa[15:0]};
      end
      S_P7: begin
        mul_a = (pp << 31) - bb;
        mul_b = 64'd3125;
      end
      S_P8: begin
        mul_a = bmc_pkg::sx16(cal.pc);
        mul_b = q13;
      end
      S_P9: begin
        mul_a = c;
        mul_b = q13;
      end
      S_P10: begin
        mul_a = bmc_pkg::sx16(cal.pb[63:48]);
        mul_b = pn;
      end
      S_H1: begin
        mul_a = {{52{cal.hum[55]}}, cal.hum[55:44]};
        mul_b = bmc_pkg::sx32(hvv);
      end
      S_H2: begin
        mul_a = bmc_pkg::sx32(hvv);
        mul_b = {{56{cal.hum[63]}}, cal.hum[63:56]};
      end
      S_H3: begin
        mul_a = bmc_pkg::sx32(hvv);
        mul_b = {56'd0, cal.hum[31:24]};
      end
      S_H4: begin
        mul_a = bmc_pkg::sx32(hy);
        mul_b = bmc_pkg::sx32(hy2);
      end
      S_H5: begin
        mul_a = bmc_pkg::sx32(hy);
        mul_b = bmc_pkg::sx16(cal.hum[23:8]);
      end
      S_H6: begin
        mul_a = bmc_pkg::sx32(hx);
        mul_b = bmc_pkg::sx32(hz);
      end
      S_H7: begin
        mul_a = bmc_pkg::sx32(bmc_pkg::asr32(hv, 15));
        mul_b = bmc_pkg::sx32(bmc_pkg::asr32(hv, 15));
      end
      S_H8: begin
        mul_a = bmc_pkg::sx32(hy);
        mul_b = {56'd0, cal.hum[7:0]};
      end
      default: begin
        mul_a = 64'd0;
        mul_b = 64'd0;
      end
    endcase
  end

  assign q_pop  = (st == S_IDLE) && !q_empty;
  assign mul_go = (st != S_IDLE) && (st != S_PDIV) && !pend;
  assign div_go = (st == S_PDIV) && !pend;

  bmc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mp)
  );

  bmc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .n    (pn),
    .d    (s),
    .done (div_done),
    .q    (dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (st == S_IDLE) begin
        if (!q_empty) begin
          raw <= q_head;
          st  <= S_T1;
        end
      end else if (!pend) begin
        pend <= 1'b1;
      end else if ((st == S_PDIV) ? div_done : mul_done) begin
        pend <= 1'b0;
        case (st)
          S_T1: begin
            v1 <= bmc_pkg::asr32(mp[31:0], 11);
            st <= S_T2;
          end
          S_T2: begin
            // v1 now carries dt^2>>12; the old v1 moves to the tf slot
            tf <= v1;
            v1 <= bmc_pkg::asr32(mp[31:0], 12);
            st <= S_T3;
          end
          S_T3: begin
            tf          <= tf + bmc_pkg::asr32(mp[31:0], 14);
            temperature <= bmc_pkg::asr32(
                             (tf + bmc_pkg::asr32(mp[31:0], 14)) * 32'd5 + 32'd128, 8);
            st          <= S_P1;
          end
          S_P1: begin
            aa <= mp;
            st <= S_P2;
          end
          S_P2: begin
            bb <= mp;
            st <= S_P3;
          end
          S_P3: begin
            bb <= bb + (mp << 17) + (bmc_pkg::sx16(cal.pa[63:48]) << 35);
            st <= S_P4;
          end
          S_P4: begin
            s  <= bmc_pkg::asr64(mp, 8);
            st <= S_P5;
          end
          S_P5: begin
            s  <= s + (mp << 12);
            st <= S_P6;
          end
          S_P6: begin
            s <= bmc_pkg::asr64(mp, 33);
            // zero divisor: pressure forced to zero
            if (bmc_pkg::asr64(mp, 33) == 64'd0) begin
              pressure       <= 32'd0;
              pressure_valid <= 1'b0;
              st             <= S_H1;
            end else begin
              st <= S_P7;
            end
          end
          S_P7: begin
            pn <= mp;
            st <= S_PDIV;
          end
          S_PDIV: begin
            pn <= dq;
            st <= S_P8;
          end
          S_P8: begin
            c  <= mp;
            st <= S_P9;
          end
          S_P9: begin
            c  <= bmc_pkg::asr64(mp, 25);
            st <= S_P10;
          end
          S_P10: begin
            pressure       <= pfin[31:0];
            pressure_valid <= 1'b1;
            st             <= S_H1;
          end
          S_H1: begin
            hx <= bmc_pkg::asr32({2'b00, raw.adc_h, 14'd0} - {cal.hum[43:32], 20'd0}
                                 - mp[31:0] + 32'd16384, 15);
            st <= S_H2;
          end
          S_H2: begin
            hy <= bmc_pkg::asr32(mp[31:0], 10);
            st <= S_H3;
          end
          S_H3: begin
            hy2 <= bmc_pkg::asr32(mp[31:0], 11) + 32'd32768;
            st  <= S_H4;
          end
          S_H4: begin
            hy <= bmc_pkg::asr32(mp[31:0], 10) + 32'd2097152;
            st <= S_H5;
          end
          S_H5: begin
            hz <= bmc_pkg::asr32(mp[31:0] + 32'd8192, 14);
            st <= S_H6;
          end
          S_H6: begin
            hv <= mp[31:0];
            st <= S_H7;
          end
          S_H7: begin
            hy <= bmc_pkg::asr32(mp[31:0], 7);
            st <= S_H8;
          end
          S_H8: begin
            humidity <= hclamp[28:12];
            done     <= 1'b1;
            st       <= S_IDLE;
          end
          default: begin
            st <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule
